// ===== rtl/core/lict_pkg.sv =====
// Shared constants for the LRU identifier cache tracker.
`default_nettype none

package lict_pkg;

    // Default geometry of the cache.
    localparam int DEF_CACHE_ENTRIES = 8;
    localparam int DEF_ID_BITS       = 16;

    // Fixed field widths of the streams.
    localparam int FRAME_ID_W  = 16;
    localparam int EVICT_ID_W  = 16;
    localparam int SLOT_FIELD_W = 3;

    // Result word: hit, evicted, evicted_id, slot, padded to whole bytes.
    localparam int RES_BITS    = 2 + EVICT_ID_W + SLOT_FIELD_W;
    localparam int OUT_TDATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - RES_BITS;

endpackage : lict_pkg

`default_nettype wire

// ===== rtl/core/lru_id_cache_tracker_unit.sv =====
// Fully associative LRU identifier cache with per-lookup hit, eviction and slot report.
//
// Usage: every word on the slave stream carries one frame identifier to look up.
// Every lookup produces exactly one result word on the master stream, in order.
// Only the low ID_BITS bits of the identifier take part in the compare and store.
// On a hit the entry becomes the most recent; on a miss the identifier takes the
// lowest-numbered empty slot, or, with the cache full, the least recent slot,
// whose identifier is then reported as evicted.
// A word accepted on the slave stream is taken into the input register, then looked
// up and written to the result register once that register is free or being read.
// Throughput is one lookup per cycle while the receiver takes the results; the
// figure is set by the single pass through the tag compare and age update logic
// between the input and the result register.
// Reset empties the cache (all valid bits and ages cleared) and drops both
// pipeline registers. When the receiver stalls, the result register holds its
// word, the pending lookup waits in the input register without touching the
// cache state, and s_axis_tready falls until the result is taken.
`default_nettype none

module lru_id_cache_tracker_unit #(
    parameter int CACHE_ENTRIES = lict_pkg::DEF_CACHE_ENTRIES,
    parameter int ID_BITS       = lict_pkg::DEF_ID_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [lict_pkg::FRAME_ID_W-1:0]   s_axis_tdata,   // [15:0] frame_id

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] hit, [1] evicted, [17:2] evicted_id, [20:18] slot, [23:21] zero
    output logic [lict_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int TAG_W  = (ID_BITS < lict_pkg::FRAME_ID_W) ? ID_BITS : lict_pkg::FRAME_ID_W;
    localparam int SLOT_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int AGE_W  = SLOT_W;
    localparam logic [AGE_W-1:0] OLDEST_AGE = AGE_W'(CACHE_ENTRIES - 1);

    // Input register
    logic               in_valid_reg;
    logic [TAG_W-1:0]   in_id_reg;

    // Result register
    logic                                  out_valid_reg;
    logic                                  out_hit_reg;
    logic                                  out_evicted_reg;
    logic [lict_pkg::EVICT_ID_W-1:0]       out_evicted_id_reg;
    logic [lict_pkg::SLOT_FIELD_W-1:0]     out_slot_reg;

    // Cache state
    logic [TAG_W-1:0]         tag_reg   [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] valid_reg;
    logic [CACHE_ENTRIES-1:0] valid_next;
    logic [AGE_W-1:0]         age_reg   [CACHE_ENTRIES];
    logic [AGE_W-1:0]         age_next  [CACHE_ENTRIES];

    logic                     advance;
    logic [CACHE_ENTRIES-1:0] match_vec;
    logic [CACHE_ENTRIES-1:0] oldest_vec;
    logic                     hit_any;
    logic                     free_any;
    logic                     evict;
    logic [SLOT_W-1:0]        match_idx;
    logic [SLOT_W-1:0]        free_idx;
    logic [SLOT_W-1:0]        oldest_idx;
    logic [SLOT_W-1:0]        slot_sel;
    logic [AGE_W-1:0]         hit_age;
    logic [TAG_W-1:0]         victim_tag;

    // The lookup in the input register completes when the result register is free.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        hit_age    = '0;
        victim_tag = '0;
        match_idx  = '0;
        free_idx   = '0;
        oldest_idx = '0;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            match_vec[i]  = valid_reg[i] && (tag_reg[i] == in_id_reg);
            oldest_vec[i] = valid_reg[i] && (age_reg[i] == OLDEST_AGE);
            if (match_vec[i])
            begin
                hit_age = hit_age | age_reg[i];
            end
            if (oldest_vec[i])
            begin
                victim_tag = victim_tag | tag_reg[i];
            end
        end
        // Scan downwards so the lowest-numbered slot wins.
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_idx = SLOT_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
            if (oldest_vec[i])
            begin
                oldest_idx = SLOT_W'(i);
            end
        end
    end

    assign hit_any  = |match_vec;
    assign free_any = ~(&valid_reg);
    assign evict    = !hit_any && !free_any;
    assign slot_sel = hit_any ? match_idx : (free_any ? free_idx : oldest_idx);

    // On a hit only entries younger than the hit one age; on a miss every other
    // valid entry ages. The chosen slot always becomes the most recent.
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            age_next[i] = age_reg[i];
            if (advance)
            begin
                if (SLOT_W'(i) == slot_sel)
                begin
                    age_next[i]   = '0;
                    valid_next[i] = 1'b1;
                end
                else if (valid_reg[i] && (!hit_any || (age_reg[i] < hit_age)))
                begin
                    age_next[i] = age_reg[i] + AGE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CACHE_ENTRIES; i++)
        begin
            if (advance && !hit_any && (SLOT_W'(i) == slot_sel))
            begin
                tag_reg[i] <= in_id_reg;
            end
        end
    end

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_id_reg <= s_axis_tdata[TAG_W-1:0];
        end
        if (advance)
        begin
            out_hit_reg        <= hit_any;
            out_evicted_reg    <= evict;
            out_evicted_id_reg <= evict ? lict_pkg::EVICT_ID_W'(victim_tag)
                                        : '0;
            out_slot_reg       <= lict_pkg::SLOT_FIELD_W'(slot_sel);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{lict_pkg::OUT_PAD_W{1'b0}}, out_slot_reg,
                            out_evicted_id_reg, out_evicted_reg, out_hit_reg};

    // A result never reports both a hit and an eviction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_evicted_reg))
        else $error("result flags both hit and eviction");

    // The evicted identifier is zero whenever nothing was evicted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_evicted_reg) |-> (out_evicted_id_reg == '0))
        else $error("evicted identifier set without an eviction");

    // Entries are never released, so occupancy never falls.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) >= $countones($past(valid_reg))))
        else $error("cache occupancy decreased");

    // An eviction happens only on a lookup that found every slot occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && evict) |-> (&valid_reg) && ($countones(oldest_vec) == 1))
        else $error("eviction without a single least recent entry");

endmodule : lru_id_cache_tracker_unit

`default_nettype wire

// ===== verif/tb_lru_id_cache_tracker_unit.sv =====
// Self-checking testbench for the LRU identifier cache tracker with randomised stream pacing.
`default_nettype none

module tb_lru_id_cache_tracker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = lict_pkg::DEF_CACHE_ENTRIES;
    localparam int TAG_BITS    = lict_pkg::DEF_ID_BITS;
    localparam int RANK_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RANDOM_IDS  = 800;
    localparam int MAX_GAP     = 17;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    localparam logic [31:0] TAG_MASK = 32'((64'd1 << TAG_BITS) - 64'd1);

    typedef struct packed {
        logic                              hit;
        logic                              evicted;
        logic [lict_pkg::EVICT_ID_W-1:0]   evicted_id;
        logic [lict_pkg::SLOT_FIELD_W-1:0] slot;
    } lookup_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [lict_pkg::FRAME_ID_W-1:0]  s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [lict_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Shadow copy of the cache contents.
    logic [TAG_BITS-1:0] cache_tag   [NUM_SLOTS];
    logic                cache_valid [NUM_SLOTS];
    logic [RANK_W-1:0]   cache_rank  [NUM_SLOTS];

    logic [lict_pkg::FRAME_ID_W-1:0] pending_ids[$];
    lookup_result_t                  expected_results[$];

    int          n_errors   = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned tx_gap     = 0;
    int unsigned rx_stall   = 0;
    int unsigned rx_draw;
    bit          tx_burst   = 1'b0;
    bit          rx_burst   = 1'b0;

    lru_id_cache_tracker_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one lookup to the shadow cache and returns what the block should report.
    function automatic lookup_result_t lookup_and_update(
        input logic [lict_pkg::FRAME_ID_W-1:0] frame_id);
        logic [TAG_BITS-1:0] key;
        logic [RANK_W-1:0]   hit_rank;
        int                  match;
        int                  free_slot;
        int                  oldest;
        int                  target;
        lookup_result_t      res;
        key       = TAG_BITS'(32'(frame_id) & TAG_MASK);
        match     = -1;
        free_slot = -1;
        oldest    = -1;
        res       = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (cache_valid[i])
            begin
                if (match < 0 && cache_tag[i] == key)
                    match = i;
                if (oldest < 0 || cache_rank[i] > cache_rank[oldest])
                    oldest = i;
            end
            else if (free_slot < 0)
            begin
                free_slot = i;
            end
        end
        if (match >= 0)
        begin
            // Only entries more recent than the hit one move back a place.
            hit_rank = cache_rank[match];
            target   = match;
            res.hit  = 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++)
                if (cache_valid[i] && cache_rank[i] < hit_rank)
                    cache_rank[i] = cache_rank[i] + 1'b1;
        end
        else
        begin
            if (free_slot >= 0)
            begin
                target = free_slot;
            end
            else
            begin
                target              = oldest;
                res.evicted         = 1'b1;
                res.evicted_id      = lict_pkg::EVICT_ID_W'(cache_tag[oldest]);
                cache_valid[oldest] = 1'b0;
            end
            for (int i = 0; i < NUM_SLOTS; i++)
                if (cache_valid[i])
                    cache_rank[i] = cache_rank[i] + 1'b1;
            cache_tag[target]   = key;
            cache_valid[target] = 1'b1;
        end
        cache_rank[target] = '0;
        res.slot = lict_pkg::SLOT_FIELD_W'(target);
        return res;
    endfunction

    function automatic int unsigned draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            n_errors++;
        end
    endtask

    // Source side: one word at a time from the pending queue, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_gap        <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results = {expected_results, lookup_and_update(s_axis_tdata)};
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap        <= tx_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_ids.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_ids.pop_front();
                    if ($urandom_range(0, 31) == 0)
                        tx_burst = ~tx_burst;
                    tx_gap <= draw_gap(tx_burst);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Sink side: compare each result word with the oldest prediction, then stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall      <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result word 0x%0h arrived with no lookup outstanding", m_axis_tdata);
                n_errors++;
            end
            else
            begin
                lookup_result_t exp_res;
                exp_res = expected_results.pop_front();
                check_field("hit", 32'(exp_res.hit), 32'(m_axis_tdata[0]));
                check_field("evicted", 32'(exp_res.evicted), 32'(m_axis_tdata[1]));
                check_field("evicted_id", 32'(exp_res.evicted_id), 32'(m_axis_tdata[17:2]));
                check_field("slot", 32'(exp_res.slot), 32'(m_axis_tdata[20:18]));
                check_field("padding", 32'd0,
                            32'(m_axis_tdata[lict_pkg::OUT_TDATA_W-1:lict_pkg::RES_BITS]));
            end
            if ($urandom_range(0, 31) == 0)
                rx_burst = ~rx_burst;
            rx_draw = draw_gap(rx_burst);
            rx_stall      <= rx_draw;
            m_axis_tready <= (rx_draw == 0);
        end
        else if (rx_stall != 0)
        begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= (rx_stall == 1);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [lict_pkg::FRAME_ID_W-1:0] id_pool[$];
        int unsigned                     pool_size;

        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            cache_tag[i]   = '0;
            cache_valid[i] = 1'b0;
            cache_rank[i]  = '0;
        end

        // Fill the empty cache, hit on the newest and a middle entry, then force evictions
        // including the return of an identifier that has just been thrown out.
        pending_ids = '{16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'h0001,
                        16'h8000, 16'h1234, 16'h00FF, 16'h00FF, 16'hFFFF, 16'hFF00,
                        16'h0F0F, 16'hAAAA, 16'h5555, 16'hF0F0, 16'h0001, 16'h8000,
                        16'h5555, 16'h7FFE, 16'h0000};

        // Random part: phases drawing mostly from a small working set, so that hits,
        // evictions and re-insertions all happen; the rest is fully random noise.
        while (pending_ids.size() < RANDOM_IDS + 21)
        begin
            id_pool.delete();
            pool_size = $urandom_range(2, 2 * NUM_SLOTS);
            for (int unsigned k = 0; k < pool_size; k++)
                id_pool = {id_pool, lict_pkg::FRAME_ID_W'($urandom)};
            for (int unsigned k = 0; k < 80; k++)
            begin
                if ($urandom_range(0, 99) < 85)
                    pending_ids = {pending_ids, id_pool[$urandom_range(0, pool_size - 1)]};
                else
                    pending_ids = {pending_ids, lict_pkg::FRAME_ID_W'($urandom)};
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_ids.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule : tb_lru_id_cache_tracker_unit

`default_nettype wire

// ===== sim.f =====
rtl/core/lict_pkg.sv
rtl/core/lru_id_cache_tracker_unit.sv
verif/tb_lru_id_cache_tracker_unit.sv
